[hdl/ctm_pkg.sv]
package ctm_pkg;

  localparam int FRAC_BITS = 14;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int HALF      = 1 << (FRAC_BITS - 1);

  localparam int FRONT_STAGES = 5;
  localparam int DIV_STAGES   = 16;
  localparam int BACK_STAGES  = 5;
  localparam int NUM_STAGES   = FRONT_STAGES + DIV_STAGES + BACK_STAGES;

  localparam int CFG_W = 15;
  localparam int IDX_W = 3;

  localparam logic [IDX_W-1:0] REG_PIVOT_CAP      = 3'd0;
  localparam logic [IDX_W-1:0] REG_THROTTLE_TAPER = 3'd1;
  localparam logic [IDX_W-1:0] REG_TURN_TRACK_CAP = 3'd2;
  localparam logic [IDX_W-1:0] REG_BLEND_START    = 3'd3;
  localparam logic [IDX_W-1:0] REG_BLEND_END      = 3'd4;

  typedef struct packed {
    logic [CFG_W-1:0] pivot_cap;
    logic [CFG_W-1:0] throttle_taper;
    logic [CFG_W-1:0] turn_track_cap;
    logic [CFG_W-1:0] blend_start;
    logic [CFG_W-1:0] blend_end;
  } cfg_t;

  // round to nearest on a product magnitude, ties away from zero
  function automatic logic [39:0] qrnd(input logic [39:0] p);
    return (p + 40'(HALF)) >> FRAC_BITS;
  endfunction

  function automatic logic [17:0] sgn18(input logic neg, input logic [16:0] m);
    return neg ? (18'd0 - {1'b0, m}) : {1'b0, m};
  endfunction

  function automatic logic [16:0] mag18(input logic [17:0] v);
    logic [17:0] n;
    n = 18'd0 - v;
    return v[17] ? n[16:0] : v[16:0];
  endfunction

  function automatic logic [16:0] sat17(input logic [19:0] v);
    logic [16:0] r;
    if ($signed(v) > $signed(20'sd65535)) begin
      r = 17'h0FFFF;
    end else if ($signed(v) < $signed(-20'sd65536)) begin
      r = 17'h10000;
    end else begin
      r = v[16:0];
    end
    return r;
  endfunction

endpackage

[hdl/ctm_front.sv]
module ctm_front
  import ctm_pkg::*;
(
  input  logic        clk,
  input  logic [4:0]  en,
  input  cfg_t        cfg,
  input  logic [15:0] throttle,
  input  logic [15:0] steering,
  input  logic [14:0] gear_scale,
  output logic [33:0] cl_num,
  output logic [33:0] cr_num,
  output logic [17:0] desat_den,
  output logic [30:0] blend_num,
  output logic [15:0] blend_den,
  output logic [17:0] cl,
  output logic [17:0] cr,
  output logic [17:0] pl,
  output logic [17:0] pr,
  output logic        desat,
  output logic        tfix,
  output logic        tone
);

  // stage a
  logic        xn_a_r, zn_a_r, zpos_a_r, dn_a_r, tfix_a_r, tone_a_r;
  logic [14:0] ax_a_r, az_a_r, capm_a_r, g_a_r;
  logic [29:0] p_tz_a_r, p_avg_a_r, p_ce_a_r;
  logic [30:0] bnum_a_r;
  logic [15:0] bden_a_r;

  logic [16:0] xe, ze, xabs, zabs, dce;
  logic [14:0] ax_nxt, az_nxt, capm_nxt, dmag, span, bdiff;
  logic        tfix_nxt, tone_nxt;

  always_comb begin
    xe   = {throttle[15], throttle};
    ze   = {steering[15], steering};
    xabs = xe[16] ? (17'd0 - xe) : xe;
    zabs = ze[16] ? (17'd0 - ze) : ze;
    ax_nxt = (xabs > 17'(ONE)) ? 15'(ONE) : xabs[14:0];
    az_nxt = (zabs > 17'(ONE)) ? 15'(ONE) : zabs[14:0];
    capm_nxt = (az_nxt < cfg.pivot_cap) ? az_nxt : cfg.pivot_cap;
    dce  = 17'(ONE) - {2'b00, cfg.turn_track_cap};
    dmag = dce[16] ? 15'(17'd0 - dce) : dce[14:0];
    span  = cfg.blend_end - cfg.blend_start;
    bdiff = ax_nxt - cfg.blend_start;
    if (cfg.blend_end > cfg.blend_start) begin
      if (ax_nxt <= cfg.blend_start) begin
        tfix_nxt = 1'b1;
        tone_nxt = 1'b0;
      end else if (ax_nxt >= cfg.blend_end) begin
        tfix_nxt = 1'b1;
        tone_nxt = 1'b1;
      end else begin
        tfix_nxt = 1'b0;
        tone_nxt = 1'b0;
      end
    end else begin
      tfix_nxt = 1'b1;
      tone_nxt = (ax_nxt >= cfg.blend_start);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      xn_a_r    <= throttle[15];
      zn_a_r    <= steering[15];
      zpos_a_r  <= !steering[15] && (steering != 16'd0);
      ax_a_r    <= ax_nxt;
      az_a_r    <= az_nxt;
      capm_a_r  <= capm_nxt;
      g_a_r     <= gear_scale;
      p_tz_a_r  <= 30'(cfg.throttle_taper) * 30'(az_nxt);
      p_avg_a_r <= 30'(ax_nxt) * 30'(gear_scale);
      dn_a_r    <= dce[16];
      p_ce_a_r  <= 30'(dmag) * 30'(az_nxt);
      tfix_a_r  <= tfix_nxt;
      tone_a_r  <= tone_nxt;
      bnum_a_r  <= 31'({bdiff, 15'd0}) + 31'(span);
      bden_a_r  <= {span, 1'b0};
    end
  end

  // stage b
  logic        xn_b_r, zn_b_r, zpos_b_r, thrn_b_r, tfix_b_r, tone_b_r;
  logic [14:0] az_b_r, capm_b_r, g_b_r;
  logic [30:0] p_thr_b_r;
  logic [15:0] avgm_b_r, ceil_b_r;
  logic [30:0] bnum_b_r;
  logic [15:0] bden_b_r;

  logic [15:0] tz, km;
  logic [16:0] kk, cs, ceil17;
  logic [14:0] cem;

  always_comb begin
    tz  = 16'(qrnd(40'(p_tz_a_r)));
    kk  = 17'(ONE) - {1'b0, tz};
    km  = kk[16] ? 16'(17'd0 - kk) : kk[15:0];
    cem = 15'(qrnd(40'(p_ce_a_r)));
    cs  = dn_a_r ? (17'd0 - {2'b00, cem}) : {2'b00, cem};
    ceil17 = 17'(ONE) - cs;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      xn_b_r    <= xn_a_r;
      zn_b_r    <= zn_a_r;
      zpos_b_r  <= zpos_a_r;
      az_b_r    <= az_a_r;
      capm_b_r  <= capm_a_r;
      g_b_r     <= g_a_r;
      p_thr_b_r <= 31'(ax_a_r) * 31'(km);
      thrn_b_r  <= xn_a_r ^ kk[16];
      avgm_b_r  <= 16'(qrnd(40'(p_avg_a_r)));
      ceil_b_r  <= ceil17[15:0];
      tfix_b_r  <= tfix_a_r;
      tone_b_r  <= tone_a_r;
      bnum_b_r  <= bnum_a_r;
      bden_b_r  <= bden_a_r;
    end
  end

  // stage c
  logic        zpos_c_r, tfix_c_r, tone_c_r;
  logic [14:0] g_c_r;
  logic [17:0] avg_c_r, al_c_r, ar_c_r;
  logic [30:0] p_del_c_r;
  logic [15:0] ceil_c_r;
  logic [30:0] bnum_c_r;
  logic [15:0] bden_c_r;

  logic [15:0] thrm;
  logic [17:0] thr, capped;

  always_comb begin
    thrm   = 16'(qrnd(40'(p_thr_b_r)));
    thr    = sgn18(thrn_b_r, {1'b0, thrm});
    capped = sgn18(zn_b_r, {2'b00, capm_b_r});
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      zpos_c_r  <= zpos_b_r;
      g_c_r     <= g_b_r;
      avg_c_r   <= sgn18(xn_b_r, {1'b0, avgm_b_r});
      al_c_r    <= thr - capped;
      ar_c_r    <= thr + capped;
      p_del_c_r <= 31'(avgm_b_r) * 31'(az_b_r);
      ceil_c_r  <= ceil_b_r;
      tfix_c_r  <= tfix_b_r;
      tone_c_r  <= tone_b_r;
      bnum_c_r  <= bnum_b_r;
      bden_c_r  <= bden_b_r;
    end
  end

  // stage d
  logic [17:0] cl_d_r, cr_d_r;
  logic [16:0] peak_d_r;
  logic [31:0] p_pl_d_r, p_pr_d_r;
  logic        pln_d_r, prn_d_r, tfix_d_r, tone_d_r;
  logic [15:0] ceil_d_r;
  logic [30:0] bnum_d_r;
  logic [15:0] bden_d_r;

  logic [17:0] d18, cl_nxt, cr_nxt;
  logic [16:0] clm, crm;

  always_comb begin
    d18    = {2'b00, 16'(qrnd(40'(p_del_c_r)))};
    cl_nxt = zpos_c_r ? (avg_c_r - d18) : (avg_c_r + d18);
    cr_nxt = zpos_c_r ? (avg_c_r + d18) : (avg_c_r - d18);
    clm    = mag18(cl_nxt);
    crm    = mag18(cr_nxt);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      cl_d_r   <= cl_nxt;
      cr_d_r   <= cr_nxt;
      peak_d_r <= (clm > crm) ? clm : crm;
      p_pl_d_r <= 32'(mag18(al_c_r)) * 32'(g_c_r);
      p_pr_d_r <= 32'(mag18(ar_c_r)) * 32'(g_c_r);
      pln_d_r  <= al_c_r[17];
      prn_d_r  <= ar_c_r[17];
      ceil_d_r <= ceil_c_r;
      tfix_d_r <= tfix_c_r;
      tone_d_r <= tone_c_r;
      bnum_d_r <= bnum_c_r;
      bden_d_r <= bden_c_r;
    end
  end

  // stage e
  logic [32:0] p_ncl_e_r, p_ncr_e_r;
  logic [16:0] peak_e_r;
  logic [17:0] cl_e_r, cr_e_r, pl_e_r, pr_e_r;
  logic        desat_e_r, tfix_e_r, tone_e_r;
  logic [30:0] bnum_e_r;
  logic [15:0] bden_e_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      p_ncl_e_r <= 33'(mag18(cl_d_r)) * 33'(ceil_d_r);
      p_ncr_e_r <= 33'(mag18(cr_d_r)) * 33'(ceil_d_r);
      peak_e_r  <= peak_d_r;
      cl_e_r    <= cl_d_r;
      cr_e_r    <= cr_d_r;
      pl_e_r    <= sgn18(pln_d_r, 17'(qrnd(40'(p_pl_d_r))));
      pr_e_r    <= sgn18(prn_d_r, 17'(qrnd(40'(p_pr_d_r))));
      desat_e_r <= peak_d_r > 17'(ceil_d_r);
      tfix_e_r  <= tfix_d_r;
      tone_e_r  <= tone_d_r;
      bnum_e_r  <= bnum_d_r;
      bden_e_r  <= bden_d_r;
    end
  end

  assign cl_num    = 34'({p_ncl_e_r, 1'b0}) + 34'(peak_e_r);
  assign cr_num    = 34'({p_ncr_e_r, 1'b0}) + 34'(peak_e_r);
  assign desat_den = {peak_e_r, 1'b0};
  assign blend_num = bnum_e_r;
  assign blend_den = bden_e_r;
  assign cl        = cl_e_r;
  assign cr        = cr_e_r;
  assign pl        = pl_e_r;
  assign pr        = pr_e_r;
  assign desat     = desat_e_r;
  assign tfix      = tfix_e_r;
  assign tone      = tone_e_r;

endmodule

[hdl/ctm_div.sv]
module ctm_div
  import ctm_pkg::*;
#(
  parameter int NW = 34,
  parameter int DW = 18,
  parameter int QW = DIV_STAGES,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic [QW-1:0] en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic [QW-1:0] quo,
  output logic [SW-1:0] side_out
);

  logic [DW-1:0] rem_r  [QW];
  logic [QW-1:0] sh_r   [QW];
  logic [DW-1:0] den_r  [QW];
  logic [SW-1:0] side_r [QW];

  for (genvar gi = 0; gi < QW; gi++) begin : g_stage
    logic [DW-1:0] rem_in, den_in, rem_nxt;
    logic [QW-1:0] sh_in, sh_nxt;
    logic [SW-1:0] side_s;
    logic [DW:0]   trial;
    logic [DW+1:0] diff;

    if (gi == 0) begin : g_first
      assign rem_in = DW'(num[NW-1:QW]);
      assign sh_in  = num[QW-1:0];
      assign den_in = den;
      assign side_s = side_in;
    end else begin : g_next
      assign rem_in = rem_r[gi-1];
      assign sh_in  = sh_r[gi-1];
      assign den_in = den_r[gi-1];
      assign side_s = side_r[gi-1];
    end

    always_comb begin
      trial   = {rem_in, sh_in[QW-1]};
      diff    = {1'b0, trial} - {2'b00, den_in};
      rem_nxt = diff[DW+1] ? trial[DW-1:0] : diff[DW-1:0];
      sh_nxt  = {sh_in[QW-2:0], !diff[DW+1]};
    end

    always_ff @(posedge clk) begin
      if (en[gi]) begin
        rem_r[gi]  <= rem_nxt;
        sh_r[gi]   <= sh_nxt;
        den_r[gi]  <= den_in;
        side_r[gi] <= side_s;
      end
    end
  end

  assign quo      = sh_r[QW-1];
  assign side_out = side_r[QW-1];

endmodule

[hdl/ctm_back.sv]
module ctm_back
  import ctm_pkg::*;
(
  input  logic        clk,
  input  logic [4:0]  en,
  input  logic [15:0] qcl,
  input  logic [15:0] qcr,
  input  logic [15:0] qb,
  input  logic [17:0] cl,
  input  logic [17:0] cr,
  input  logic [17:0] pl,
  input  logic [17:0] pr,
  input  logic        desat,
  input  logic        tfix,
  input  logic        tone,
  output logic [16:0] left_drive,
  output logic [16:0] right_drive
);

  // stage 1: desaturated curvature, blend ratio
  logic [17:0] clf_1_r, crf_1_r, pl_1_r, pr_1_r;
  logic [14:0] t_1_r;
  logic [29:0] p_t2_1_r;
  logic [14:0] t_nxt;

  always_comb begin
    if (tfix) begin
      t_nxt = tone ? 15'(ONE) : 15'd0;
    end else begin
      t_nxt = qb[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      clf_1_r  <= desat ? sgn18(cl[17], {1'b0, qcl}) : cl;
      crf_1_r  <= desat ? sgn18(cr[17], {1'b0, qcr}) : cr;
      pl_1_r   <= pl;
      pr_1_r   <= pr;
      t_1_r    <= t_nxt;
      p_t2_1_r <= 30'(t_nxt) * 30'(t_nxt);
    end
  end

  // stage 2: smoothstep product
  logic [17:0] clf_2_r, crf_2_r, pl_2_r, pr_2_r;
  logic [30:0] p_s_2_r;
  logic [14:0] t2;
  logic [15:0] u;

  always_comb begin
    t2 = 15'(qrnd(40'(p_t2_1_r)));
    u  = 16'(3 * ONE) - {t_1_r, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      clf_2_r <= clf_1_r;
      crf_2_r <= crf_1_r;
      pl_2_r  <= pl_1_r;
      pr_2_r  <= pr_1_r;
      p_s_2_r <= 31'(t2) * 31'(u);
    end
  end

  // stage 3: blend weights
  logic [17:0] clf_3_r, crf_3_r, pl_3_r, pr_3_r;
  logic [15:0] s_3_r, wm_3_r;
  logic        wn_3_r;
  logic [15:0] s_nxt;
  logic [16:0] ww;

  always_comb begin
    s_nxt = 16'(qrnd(40'(p_s_2_r)));
    ww    = 17'(ONE) - {1'b0, s_nxt};
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      clf_3_r <= clf_2_r;
      crf_3_r <= crf_2_r;
      pl_3_r  <= pl_2_r;
      pr_3_r  <= pr_2_r;
      s_3_r   <= s_nxt;
      wn_3_r  <= ww[16];
      wm_3_r  <= ww[16] ? 16'(17'd0 - ww) : ww[15:0];
    end
  end

  // stage 4: weighted products
  logic [32:0] pp_pl_4_r, pp_pr_4_r, pp_cl_4_r, pp_cr_4_r;
  logic        npl_4_r, npr_4_r, ncl_4_r, ncr_4_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      pp_pl_4_r <= 33'(mag18(pl_3_r)) * 33'(wm_3_r);
      pp_pr_4_r <= 33'(mag18(pr_3_r)) * 33'(wm_3_r);
      pp_cl_4_r <= 33'(mag18(clf_3_r)) * 33'(s_3_r);
      pp_cr_4_r <= 33'(mag18(crf_3_r)) * 33'(s_3_r);
      npl_4_r   <= pl_3_r[17] ^ wn_3_r;
      npr_4_r   <= pr_3_r[17] ^ wn_3_r;
      ncl_4_r   <= clf_3_r[17];
      ncr_4_r   <= crf_3_r[17];
    end
  end

  // stage 5: sum and saturate into the output register
  logic [16:0] left_r, right_r;
  logic [17:0] a_l, b_l, a_r, b_r;
  logic [19:0] sum_l, sum_r;

  always_comb begin
    a_l   = sgn18(npl_4_r, 17'(qrnd(40'(pp_pl_4_r))));
    b_l   = sgn18(ncl_4_r, 17'(qrnd(40'(pp_cl_4_r))));
    a_r   = sgn18(npr_4_r, 17'(qrnd(40'(pp_pr_4_r))));
    b_r   = sgn18(ncr_4_r, 17'(qrnd(40'(pp_cr_4_r))));
    sum_l = {{2{a_l[17]}}, a_l} + {{2{b_l[17]}}, b_l};
    sum_r = {{2{a_r[17]}}, a_r} + {{2{b_r[17]}}, b_r};
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      left_r  <= sat17(sum_l);
      right_r <= sat17(sum_r);
    end
  end

  assign left_drive  = left_r;
  assign right_drive = right_r;

endmodule

[hdl/curvature_tank_track_mixer_top.sv]
// Curvature tank track mixer: turns throttle, steering and gear into left and
// right track drives (Q2.14), blending a pivot mix and a desaturated curvature
// mix by a smoothstep of throttle magnitude. Fully pipelined: one transaction
// per clock is accepted while the output is not stalled, and each result
// passes through bit-per-stage restoring dividers for desaturation and the
// blend ratio. The block holds no state across transactions. When the output
// is stalled, empty pipeline stages still fill, so in_stall rises only once
// every stage holds a transaction. Registers are written through the cfg port
// (always ready); the user must write them only while no transaction is in
// flight, not enforced by the block itself. Writes above index 4 are dropped.
module curvature_tank_track_mixer_top
  import ctm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [15:0]      in_throttle,
  input  logic [15:0]      in_steering,
  input  logic [14:0]      in_gear_scale,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [16:0]      out_left_drive,
  output logic [16:0]      out_right_drive,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int DIV0 = FRONT_STAGES;
  localparam int BCK0 = FRONT_STAGES + DIV_STAGES;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pivot_cap      <= CFG_W'(ONE / 2);
      cfg_r.throttle_taper <= CFG_W'(ONE / 2);
      cfg_r.turn_track_cap <= CFG_W'(ONE);
      cfg_r.blend_start    <= '0;
      cfg_r.blend_end      <= CFG_W'(ONE / 2);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PIVOT_CAP:      cfg_r.pivot_cap      <= cfg_wdata;
        REG_THROTTLE_TAPER: cfg_r.throttle_taper <= cfg_wdata;
        REG_TURN_TRACK_CAP: cfg_r.turn_track_cap <= cfg_wdata;
        REG_BLEND_START:    cfg_r.blend_start    <= cfg_wdata;
        REG_BLEND_END:      cfg_r.blend_end      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // per-stage valid and advance
  logic [NUM_STAGES-1:0] vld_r, vld_nxt, en;

  assign en[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || !out_stall;
  for (genvar k = 0; k < NUM_STAGES - 1; k++) begin : g_en
    assign en[k] = !vld_r[k] || en[k+1];
  end

  always_comb begin
    for (int k = 0; k < NUM_STAGES; k++) begin
      if (en[k]) begin
        vld_nxt[k] = (k == 0) ? in_valid : vld_r[(k == 0) ? 0 : k - 1];
      end else begin
        vld_nxt[k] = vld_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld_r[NUM_STAGES-1];

  logic [33:0] cl_num, cr_num;
  logic [17:0] desat_den;
  logic [30:0] blend_num;
  logic [15:0] blend_den;
  logic [17:0] cl, cr, pl, pr;
  logic        desat, tfix, tone;

  ctm_front u_front (
    .clk        (clk),
    .en         (en[DIV0-1:0]),
    .cfg        (cfg_r),
    .throttle   (in_throttle),
    .steering   (in_steering),
    .gear_scale (in_gear_scale),
    .cl_num     (cl_num),
    .cr_num     (cr_num),
    .desat_den  (desat_den),
    .blend_num  (blend_num),
    .blend_den  (blend_den),
    .cl         (cl),
    .cr         (cr),
    .pl         (pl),
    .pr         (pr),
    .desat      (desat),
    .tfix       (tfix),
    .tone       (tone)
  );

  logic [15:0] qcl, qcr, qb;
  logic [36:0] side_l;
  logic [35:0] side_r;
  logic [1:0]  side_b;

  ctm_div #(.NW(34), .DW(18), .QW(DIV_STAGES), .SW(37)) u_div_l (
    .clk      (clk),
    .en       (en[BCK0-1:DIV0]),
    .num      (cl_num),
    .den      (desat_den),
    .side_in  ({desat, cl, pl}),
    .quo      (qcl),
    .side_out (side_l)
  );

  ctm_div #(.NW(34), .DW(18), .QW(DIV_STAGES), .SW(36)) u_div_r (
    .clk      (clk),
    .en       (en[BCK0-1:DIV0]),
    .num      (cr_num),
    .den      (desat_den),
    .side_in  ({cr, pr}),
    .quo      (qcr),
    .side_out (side_r)
  );

  ctm_div #(.NW(31), .DW(16), .QW(DIV_STAGES), .SW(2)) u_div_b (
    .clk      (clk),
    .en       (en[BCK0-1:DIV0]),
    .num      (blend_num),
    .den      (blend_den),
    .side_in  ({tfix, tone}),
    .quo      (qb),
    .side_out (side_b)
  );

  ctm_back u_back (
    .clk         (clk),
    .en          (en[NUM_STAGES-1:BCK0]),
    .qcl         (qcl),
    .qcr         (qcr),
    .qb          (qb),
    .cl          (side_l[35:18]),
    .cr          (side_r[35:18]),
    .pl          (side_l[17:0]),
    .pr          (side_r[17:0]),
    .desat       (side_l[36]),
    .tfix        (side_b[1]),
    .tone        (side_b[0]),
    .left_drive  (out_left_drive),
    .right_drive (out_right_drive)
  );

endmodule

[hdl/ctm_checker.sv]
module ctm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [16:0] out_left_drive,
  input logic [16:0] out_right_drive
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_left_drive) && $stable(out_right_drive))
    else $error("output payload changed while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // backpressure only comes from a stalled output
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output is free");

endmodule

bind curvature_tank_track_mixer_top ctm_checker u_ctm_checker (.*);
